### rtl/core/dsd_pkg.sv
// Shared types, constants and calendar helpers for the date serial-day converter.
package dsd_pkg;

  localparam int BASE_YEAR_DEF = 1900;
  localparam int YEAR_SPAN_DEF = 256;

  // year arithmetic width, wide enough for any base year plus span
  localparam int YR_W = 16;

  // 5243 / 2^17 ~ 1/25, exact floor for the 14-bit quotients used here
  localparam logic [12:0] RECIP25 = 13'd5243;

  typedef logic [YR_W-1:0] yr_t;

  // per-item results of the forward path, carried alongside the sum path
  typedef struct packed {
    logic        first_valid;
    logic        second_valid;
    logic [16:0] first_serial;
    logic [16:0] second_serial;
    logic        second_not_before;
    logic [17:0] serial_difference;
  } front_t;

  function automatic yr_t div100(yr_t x);
    logic [27:0] p;
    p = 28'(x[YR_W-1:2]) * 28'(RECIP25);
    return yr_t'(p >> 17);
  endfunction

  function automatic yr_t div400(yr_t x);
    logic [27:0] p;
    p = 28'(x[YR_W-1:4]) * 28'(RECIP25);
    return yr_t'(p >> 17);
  endfunction

  // q100 and q400 are y/100 and y/400
  function automatic logic is_leap(yr_t y, yr_t q100, yr_t q400);
    logic div4;
    logic div100_hit;
    logic div400_hit;
    div4       = (y[1:0] == 2'b00);
    div100_hit = (y == yr_t'(q100 * yr_t'(100)));
    div400_hit = (y == yr_t'(q400 * yr_t'(400)));
    return (div4 && !div100_hit) || div400_hit;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m
  function automatic logic [8:0] days_before(logic [3:0] m, logic leap);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && m > 4'd2 && m < 4'd13) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

### rtl/core/dsd_date_to_serial.sv
// Three-stage date check and date to serial-day conversion.
module dsd_date_to_serial #(
  parameter int BASE_YEAR = dsd_pkg::BASE_YEAR_DEF,
  parameter int YEAR_SPAN = dsd_pkg::YEAR_SPAN_DEF,
  parameter int VW        = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [4:0]    in_day,
  input  logic [3:0]    in_month,
  input  logic [11:0]   in_year,
  output logic          out_valid,
  output logic          out_ok,
  output logic [VW-1:0] out_serial
);

  localparam int LB  = (BASE_YEAR-1)/4 - (BASE_YEAR-1)/100 + (BASE_YEAR-1)/400;
  localparam int YOW = $clog2(YEAR_SPAN+1);

  // stage 1: range check, quotients
  dsd_pkg::yr_t y16, n16, yo16;
  logic         inr_nxt;

  logic             v1_r, inr1_r;
  logic [4:0]       day1_r;
  logic [3:0]       mon1_r;
  logic [YOW-1:0]   yo1_r;
  dsd_pkg::yr_t     year1_r, q4_1_r, q100_1_r, q400_1_r, yq100_1_r, yq400_1_r;

  assign y16     = dsd_pkg::yr_t'(in_year);
  assign n16     = y16 - dsd_pkg::yr_t'(1);
  assign yo16    = y16 - dsd_pkg::yr_t'(BASE_YEAR);
  assign inr_nxt = (y16 >= dsd_pkg::yr_t'(BASE_YEAR)) && (yo16 < dsd_pkg::yr_t'(YEAR_SPAN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    inr1_r    <= inr_nxt;
    day1_r    <= in_day;
    mon1_r    <= in_month;
    yo1_r     <= yo16[YOW-1:0];
    year1_r   <= y16;
    q4_1_r    <= n16 >> 2;
    q100_1_r  <= dsd_pkg::div100(n16);
    q400_1_r  <= dsd_pkg::div400(n16);
    yq100_1_r <= dsd_pkg::div100(y16);
    yq400_1_r <= dsd_pkg::div400(y16);
  end

  // stage 2: leap, validity, days before the year and the month
  logic          leap2;
  logic [4:0]    mlen2;
  logic          ok2_nxt;
  logic [VW-1:0] db2_nxt;

  logic          v2_r, ok2_r;
  logic [VW-1:0] db2_r;
  logic [8:0]    cum2_r;
  logic [4:0]    day2_r;

  assign leap2   = dsd_pkg::is_leap(year1_r, yq100_1_r, yq400_1_r);
  assign mlen2   = dsd_pkg::month_len(mon1_r, leap2);
  assign ok2_nxt = inr1_r && (mon1_r >= 4'd1) && (mon1_r <= 4'd12) &&
                   (day1_r != 5'd0) && (day1_r <= mlen2);
  assign db2_nxt = VW'(yo1_r) * VW'(365) + VW'(q4_1_r) - VW'(q100_1_r) +
                   VW'(q400_1_r) - VW'(LB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ok2_r  <= ok2_nxt;
    db2_r  <= db2_nxt;
    cum2_r <= dsd_pkg::days_before(mon1_r, leap2);
    day2_r <= day1_r;
  end

  // stage 3: serial
  logic          v3_r, ok3_r;
  logic [VW-1:0] serial3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ok3_r     <= ok2_r;
    serial3_r <= ok2_r ? (db2_r + VW'(cum2_r) + VW'(day2_r)) : '0;
  end

  assign out_valid  = v3_r;
  assign out_ok     = ok3_r;
  assign out_serial = serial3_r;

endmodule

### rtl/core/dsd_serial_to_date.sv
// Seven-stage serial-day to date conversion: year estimate, correction, month search.
module dsd_serial_to_date #(
  parameter int BASE_YEAR = dsd_pkg::BASE_YEAR_DEF,
  parameter int YEAR_SPAN = dsd_pkg::YEAR_SPAN_DEF,
  parameter int VW        = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ok,
  input  logic [VW-1:0] in_total,
  output logic          out_valid,
  output logic          out_ok,
  output logic [4:0]    out_day,
  output logic [3:0]    out_month,
  output logic [11:0]   out_year
);

  localparam int    LB    = (BASE_YEAR-1)/4 - (BASE_YEAR-1)/100 + (BASE_YEAR-1)/400;
  localparam int    EW    = $clog2(YEAR_SPAN+2);
  // 2^27 * 400 / 146097: years per day over a full Gregorian cycle
  localparam longint RECIP = (longint'(1) << 27) * 400 / 146097;

  // stage A: zero-based day, year estimate within one of the true year
  logic [VW-1:0] ta_nxt;
  logic [47:0]   prod_a;

  logic          va_r, oka_r;
  logic [VW-1:0] ta_r;
  logic [EW-1:0] ea_r;

  assign ta_nxt = in_total - VW'(1);
  assign prod_a = 48'(ta_nxt) * 48'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    oka_r <= in_ok;
    ta_r  <= ta_nxt;
    ea_r  <= EW'(prod_a >> 27);
  end

  // stage B: quotients for the estimate and its neighbors
  dsd_pkg::yr_t nb_nxt, n1b, n2b;

  logic          vb_r, okb_r;
  logic [VW-1:0] tb_r;
  logic [EW-1:0] eb_r;
  dsd_pkg::yr_t  nb_r, q4b_r, q100b_r, q400b_r;
  dsd_pkg::yr_t  q100b1_r, q400b1_r, q100b2_r, q400b2_r;

  assign nb_nxt = dsd_pkg::yr_t'(BASE_YEAR-1) + dsd_pkg::yr_t'(ea_r);
  assign n1b    = nb_nxt + dsd_pkg::yr_t'(1);
  assign n2b    = nb_nxt + dsd_pkg::yr_t'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    okb_r    <= oka_r;
    tb_r     <= ta_r;
    eb_r     <= ea_r;
    nb_r     <= nb_nxt;
    q4b_r    <= nb_nxt >> 2;
    q100b_r  <= dsd_pkg::div100(nb_nxt);
    q400b_r  <= dsd_pkg::div400(nb_nxt);
    q100b1_r <= dsd_pkg::div100(n1b);
    q400b1_r <= dsd_pkg::div400(n1b);
    q100b2_r <= dsd_pkg::div100(n2b);
    q400b2_r <= dsd_pkg::div400(n2b);
  end

  // stage C: days before the estimated year, leap flags of three years
  logic [VW-1:0] dbc_nxt;
  logic [2:0]    lpc_nxt;

  logic          vc_r, okc_r;
  logic [VW-1:0] tc_r, dbc_r;
  logic [EW-1:0] ec_r;
  logic [2:0]    lpc_r;

  assign dbc_nxt = VW'(eb_r) * VW'(365) + VW'(q4b_r) - VW'(q100b_r) + VW'(q400b_r) - VW'(LB);
  assign lpc_nxt[0] = dsd_pkg::is_leap(nb_r, q100b_r, q400b_r);
  assign lpc_nxt[1] = dsd_pkg::is_leap(nb_r + dsd_pkg::yr_t'(1), q100b1_r, q400b1_r);
  assign lpc_nxt[2] = dsd_pkg::is_leap(nb_r + dsd_pkg::yr_t'(2), q100b2_r, q400b2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    okc_r <= okb_r;
    tc_r  <= tb_r;
    ec_r  <= eb_r;
    dbc_r <= dbc_nxt;
    lpc_r <= lpc_nxt;
  end

  // stage D: step the estimate by one year where needed
  logic [VW-1:0] len_prev, len_cur, dbd_nxt;
  logic [EW-1:0] yd_nxt;
  logic          lpd_nxt;

  logic          vd_r, okd_r, lpd_r;
  logic [VW-1:0] td_r, dbd_r;
  logic [EW-1:0] yd_r;

  assign len_prev = VW'(365) + VW'(lpc_r[0]);
  assign len_cur  = VW'(365) + VW'(lpc_r[1]);

  always_comb begin
    if (tc_r < dbc_r) begin
      yd_nxt  = ec_r - EW'(1);
      dbd_nxt = dbc_r - len_prev;
      lpd_nxt = lpc_r[0];
    end else if (tc_r >= dbc_r + len_cur) begin
      yd_nxt  = ec_r + EW'(1);
      dbd_nxt = dbc_r + len_cur;
      lpd_nxt = lpc_r[2];
    end else begin
      yd_nxt  = ec_r;
      dbd_nxt = dbc_r;
      lpd_nxt = lpc_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    okd_r <= okc_r;
    td_r  <= tc_r;
    dbd_r <= dbd_nxt;
    yd_r  <= yd_nxt;
    lpd_r <= lpd_nxt;
  end

  // stage E: day within the year, calendar year
  logic       ve_r, oke_r, lpe_r;
  logic [8:0] re_r;
  logic [11:0] yre_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    oke_r <= okd_r;
    re_r  <= 9'(td_r - dbd_r);
    yre_r <= 12'(dsd_pkg::yr_t'(BASE_YEAR) + dsd_pkg::yr_t'(yd_r));
    lpe_r <= lpd_r;
  end

  // stage F: month search over the cumulative table
  logic [3:0] mf_nxt;

  logic        vf_r, okf_r;
  logic [8:0]  rf_r, cumf_r;
  logic [3:0]  mf_r;
  logic [11:0] yrf_r;

  always_comb begin
    mf_nxt = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (re_r >= dsd_pkg::days_before(4'(k), lpe_r)) begin
        mf_nxt = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    okf_r  <= oke_r;
    rf_r   <= re_r;
    mf_r   <= mf_nxt;
    cumf_r <= dsd_pkg::days_before(mf_nxt, lpe_r);
    yrf_r  <= yre_r;
  end

  // stage G: day of month, zero when out of span
  logic        vg_r, okg_r;
  logic [4:0]  dayg_r;
  logic [3:0]  mong_r;
  logic [11:0] yrg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else begin
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    okg_r  <= okf_r;
    dayg_r <= okf_r ? 5'(rf_r - cumf_r + 9'd1) : 5'd0;
    mong_r <= okf_r ? mf_r : 4'd0;
    yrg_r  <= okf_r ? yrf_r : 12'd0;
  end

  assign out_valid = vg_r;
  assign out_ok    = okg_r;
  assign out_day   = dayg_r;
  assign out_month = mong_r;
  assign out_year  = yrg_r;

endmodule

### rtl/core/date_serial_day_converter_unit.sv
// Top level of the Gregorian date serial-day converter.
//
// Usage:
//   Drive the two dates and the offset on the in_ ports and pulse start.
//   A transfer is taken at each rising edge with start high and busy low;
//   busy stays low, so a new transfer may be issued on every cycle.
//   Each date is checked and mapped to a serial day (1 January of BASE_YEAR
//   is day 1, 0 for an invalid date). The block also reports the serial
//   difference, the order of the dates, and the first date plus the offset.
// Timing:
//   A transfer goes through the date check and serial, then the compare and
//   the add, then the conversion of the sum back to a date (year estimate,
//   quotients, correction by one year, month search, day).
//   Throughput is one transfer per cycle; every stage is a register stage.
// Output:
//   out_valid is high for exactly one cycle per transfer and the fields are
//   valid in that cycle only. The receiver cannot stall the result.
// Reset:
//   Synchronous, active low. Clears the valid pipeline; items in flight are
//   dropped and no result appears for them.
module date_serial_day_converter_unit #(
  parameter int BASE_YEAR = dsd_pkg::BASE_YEAR_DEF,
  parameter int YEAR_SPAN = dsd_pkg::YEAR_SPAN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_first_day,
  input  logic [3:0]  in_first_month,
  input  logic [11:0] in_first_year,
  input  logic [4:0]  in_second_day,
  input  logic [3:0]  in_second_month,
  input  logic [11:0] in_second_year,
  input  logic [16:0] in_offset_days,
  output logic        out_valid,
  output logic        out_first_valid,
  output logic        out_second_valid,
  output logic [16:0] out_first_serial,
  output logic [16:0] out_second_serial,
  output logic        out_second_not_before,
  output logic [17:0] out_serial_difference,
  output logic [4:0]  out_sum_day,
  output logic [3:0]  out_sum_month,
  output logic [11:0] out_sum_year,
  output logic        out_sum_in_range
);

  // leap years up to the day before the span and up to its last year
  localparam int LB   = (BASE_YEAR-1)/4 - (BASE_YEAR-1)/100 + (BASE_YEAR-1)/400;
  localparam int YL   = BASE_YEAR + YEAR_SPAN - 1;
  localparam int LE   = YL/4 - YL/100 + YL/400;
  // serial of the last day of the span
  localparam int LAST = 365*YEAR_SPAN + LE - LB;
  // internal serial width: covers a year beyond the span and serial + offset
  localparam int VW0  = $clog2(LAST + 733);
  localparam int VW   = ((VW0 > 17) ? VW0 : 17) + 1;
  localparam int FRONT_LAT = 3;
  localparam int INV_LAT   = 7;

  logic accept;

  // no stall source downstream, so the pipeline never holds off a transfer
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // date check and serial, both dates in parallel
  logic          f1_valid, f1_ok, f2_valid, f2_ok;
  logic [VW-1:0] f1_serial, f2_serial;

  dsd_date_to_serial #(
    .BASE_YEAR (BASE_YEAR),
    .YEAR_SPAN (YEAR_SPAN),
    .VW        (VW)
  ) u_first (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_day     (in_first_day),
    .in_month   (in_first_month),
    .in_year    (in_first_year),
    .out_valid  (f1_valid),
    .out_ok     (f1_ok),
    .out_serial (f1_serial)
  );

  dsd_date_to_serial #(
    .BASE_YEAR (BASE_YEAR),
    .YEAR_SPAN (YEAR_SPAN),
    .VW        (VW)
  ) u_second (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_day     (in_second_day),
    .in_month   (in_second_month),
    .in_year    (in_second_year),
    .out_valid  (f2_valid),
    .out_ok     (f2_ok),
    .out_serial (f2_serial)
  );

  // offset rides alongside the serial stages
  logic [16:0] off_r [FRONT_LAT];

  always_ff @(posedge clk) begin
    off_r[0] <= in_offset_days;
    for (int i = 1; i < FRONT_LAT; i++) begin
      off_r[i] <= off_r[i-1];
    end
  end

  // compare, difference, sum and span check
  dsd_pkg::front_t front_nxt;
  logic [VW-1:0]   total_nxt;

  always_comb begin
    front_nxt.first_valid       = f1_ok;
    front_nxt.second_valid      = f2_ok;
    front_nxt.first_serial      = f1_serial[16:0];
    front_nxt.second_serial     = f2_serial[16:0];
    front_nxt.second_not_before = (f2_serial >= f1_serial);
    front_nxt.serial_difference = 18'(f2_serial - f1_serial);
  end

  assign total_nxt = f1_serial + VW'(off_r[FRONT_LAT-1]);

  logic            v4_r, sok4_r;
  dsd_pkg::front_t front4_r;
  logic [VW-1:0]   total4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= f1_valid & f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    front4_r <= front_nxt;
    total4_r <= total_nxt;
    sok4_r   <= f1_ok && (total_nxt <= VW'(LAST));
  end

  // sum back to a calendar date
  logic inv_valid, inv_ok;

  dsd_serial_to_date #(
    .BASE_YEAR (BASE_YEAR),
    .YEAR_SPAN (YEAR_SPAN),
    .VW        (VW)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_ok     (sok4_r),
    .in_total  (total4_r),
    .out_valid (inv_valid),
    .out_ok    (inv_ok),
    .out_day   (out_sum_day),
    .out_month (out_sum_month),
    .out_year  (out_sum_year)
  );

  // forward results wait for the sum conversion
  dsd_pkg::front_t dly_r [INV_LAT];

  always_ff @(posedge clk) begin
    dly_r[0] <= front4_r;
    for (int i = 1; i < INV_LAT; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign out_valid             = inv_valid;
  assign out_sum_in_range      = inv_ok;
  assign out_first_valid       = dly_r[INV_LAT-1].first_valid;
  assign out_second_valid      = dly_r[INV_LAT-1].second_valid;
  assign out_first_serial      = dly_r[INV_LAT-1].first_serial;
  assign out_second_serial     = dly_r[INV_LAT-1].second_serial;
  assign out_second_not_before = dly_r[INV_LAT-1].second_not_before;
  assign out_serial_difference = dly_r[INV_LAT-1].serial_difference;

  // a sum date only exists for a valid first date
  a_sum_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sum_in_range |-> out_first_valid)
    else $error("sum in range from an invalid first date");

  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sum_in_range |->
      out_sum_day == 5'd0 && out_sum_month == 4'd0 && out_sum_year == 12'd0)
    else $error("sum fields not cleared when out of span");

  a_invalid_serial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_first_valid |-> out_first_serial == 17'd0)
    else $error("invalid first date with nonzero serial");

  a_sum_date_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sum_in_range |->
      out_sum_day != 5'd0 && out_sum_month != 4'd0 && out_sum_month <= 4'd12)
    else $error("sum date out of calendar shape");

endmodule
